### rtl/core/aesctr_pkg.sv
// Shared types, constants and AES round functions for the AES-128 CTR core.
// No dependencies; imported by aesctr_keygen, aesctr_back and the top level.
`timescale 1ns / 1ps
package aesctr_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_out;
   } rsp_type;

   // control from the byte engine to the keystream generator
   typedef struct packed {
      logic pop;
      logic restart;
   } ks_ctl_type;

   localparam int IN_DEPTH    = 4;
   localparam int OUT_DEPTH   = 2;
   localparam int KS_DEPTH    = 2;
   localparam int ROUNDS      = 10;
   localparam int ROUND_W     = $clog2(ROUNDS + 1);
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_HIGH,
      CSR_KEY_LOW,
      CSR_CTR_HIGH,
      CSR_CTR_LOW
   } csr_index_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] round);
      logic [7:0] rc;
      case (round)
         4'd1:    rc = 8'h01;
         4'd2:    rc = 8'h02;
         4'd3:    rc = 8'h04;
         4'd4:    rc = 8'h08;
         4'd5:    rc = 8'h10;
         4'd6:    rc = 8'h20;
         4'd7:    rc = 8'h40;
         4'd8:    rc = 8'h80;
         4'd9:    rc = 8'h1b;
         4'd10:   rc = 8'h36;
         default: rc = 8'h00;
      endcase
      return rc;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block sits at bits [127-8i -: 8]
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (c * 4 + r) -: 8] = SBOX[s[127 - 8 * (((c + r) % 4) * 4 + r) -: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         t[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return t;
   endfunction

   function automatic logic [127:0] next_round_key(input logic [127:0] rk,
                                                   input logic [7:0]   rc);
      logic [31:0] w3, t, n0, n1, n2, n3;
      w3 = rk[31:0];
      t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      n0 = rk[127:96] ^ t;
      n1 = rk[95:64] ^ n0;
      n2 = rk[63:32] ^ n1;
      n3 = w3 ^ n2;
      return {n0, n1, n2, n3};
   endfunction

endpackage

### rtl/core/aesctr_fifo.sv
// Small flop-based queue with synchronous clear and fill count.
// Generic in width and depth; no dependencies.
`timescale 1ns / 1ps
module aesctr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   output logic                         full,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (clear) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         count_in  = '0;
      end else begin
         if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) count_in = count_ff + 1'b1;
         else if (do_pop && !do_push) count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push && !clear) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/aesctr_keygen.sv
// Keystream generator: iterative AES-128, one round per cycle, running ahead
// into a short block queue. Depends on aesctr_pkg and aesctr_fifo.
`timescale 1ns / 1ps
module aesctr_keygen (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [127:0]            key,
   input  logic [127:0]            init_ctr,
   input  aesctr_pkg::ks_ctl_type  ctl,
   output logic [127:0]            ks_block,
   output logic                    ks_empty
);
   import aesctr_pkg::*;

   localparam int CNT_W = $clog2(KS_DEPTH + 1);

   logic               busy_ff, busy_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [127:0]       state_ff, state_in;
   logic [127:0]       rk_ff, rk_in;
   logic [127:0]       ctr_ff, ctr_in;
   logic [127:0]       rk_next, sb, round_out;
   logic [CNT_W-1:0]   ks_count;
   logic               start, last_round, push;

   assign rk_next    = next_round_key(rk_ff, rcon(round_ff));
   assign sb         = sub_shift(state_ff);
   assign last_round = (round_ff == ROUND_W'(ROUNDS));
   assign round_out  = (last_round ? sb : mix_columns(sb)) ^ rk_next;
   assign push       = busy_ff && last_round && !ctl.restart;
   assign start      = !busy_ff && !ctl.restart && (ks_count < CNT_W'(KS_DEPTH));

   always_comb begin
      busy_in  = busy_ff;
      round_in = round_ff;
      state_in = state_ff;
      rk_in    = rk_ff;
      ctr_in   = ctr_ff;
      if (ctl.restart) begin
         busy_in = 1'b0;
         ctr_in  = init_ctr;
      end else if (start) begin
         busy_in  = 1'b1;
         round_in = ROUND_W'(1);
         state_in = ctr_ff ^ key;
         rk_in    = key;
         ctr_in   = ctr_ff + 128'd1;
      end else if (busy_ff) begin
         state_in = round_out;
         rk_in    = rk_next;
         round_in = round_ff + 1'b1;
         if (last_round) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= '0;
         ctr_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         round_ff <= round_in;
         ctr_ff   <= ctr_in;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      rk_ff    <= rk_in;
   end

   aesctr_fifo #(
      .WIDTH (128),
      .DEPTH (KS_DEPTH)
   ) u_ks_queue (
      .clock     (clock),
      .reset     (reset),
      .clear     (ctl.restart),
      .push      (push),
      .push_data (round_out),
      .full      (),
      .pop       (ctl.pop),
      .pop_data  (ks_block),
      .empty     (ks_empty),
      .count     (ks_count)
   );

endmodule

### rtl/core/aesctr_back.sv
// Byte engine: XORs queued bytes with the head keystream block and tracks
// the byte position. Depends on aesctr_pkg.
`timescale 1ns / 1ps
module aesctr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cfg_restart,
   input  aesctr_pkg::req_type     in_item,
   input  logic                    in_empty,
   output logic                    in_pop,
   input  logic [127:0]            ks_block,
   input  logic                    ks_empty,
   output aesctr_pkg::ks_ctl_type  ks_ctl,
   input  logic                    out_full,
   output logic                    out_push,
   output aesctr_pkg::rsp_type     out_item
);
   import aesctr_pkg::*;

   logic [3:0] pos_ff, pos_in;
   logic [6:0] bit_base;
   logic       fire;

   assign fire     = !in_empty && !ks_empty && !out_full;
   assign in_pop   = fire;
   assign out_push = fire;
   assign bit_base = {4'd15 - pos_ff, 3'b000};

   assign out_item.out_byte = in_item.data_byte ^ ks_block[bit_base +: 8];
   assign out_item.last_out = in_item.last_in;

   // release the block after its last byte or at message end
   assign ks_ctl.pop     = fire && ((pos_ff == 4'd15) || in_item.last_in);
   assign ks_ctl.restart = cfg_restart || (fire && in_item.last_in);

   always_comb begin
      pos_in = pos_ff;
      if (ks_ctl.restart) pos_in = '0;
      else if (fire)      pos_in = pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

### rtl/core/aes128_ctr_stream_cipher_core.sv
// Top level of the AES-128 CTR byte stream cipher.
// Depends on aesctr_pkg, aesctr_fifo, aesctr_keygen and aesctr_back.
`timescale 1ns / 1ps
// Usage:
//  req_* : input queue. Push a byte (with last_in) while req_full is low.
//  rsp_* : result queue. While rsp_empty is low, rsp_data holds the oldest
//          result; raise rsp_pop to take it.
//  csr_* : register writes (key high/low, initial counter high/low), always
//          ready. Write only while idle; every write restarts the message.
//  Each byte comes back XORed with the next keystream byte.
//  Throughput: one byte per cycle while input and keystream are queued and
//  the result queue has room. The AES unit runs up to two blocks ahead,
//  so within a message 16-byte blocks stream without gaps.
//  Path: a pushed byte is registered in the input queue, XORed by the byte
//  engine and registered in the result queue. The first byte of a message
//  (after reset, a csr write or a last byte) waits for its first AES block.
//  Reset zeroes the csrs, queues and counter, not AES state or round key.
//  When rsp_pop stays low the result queue fills, the byte engine holds,
//  and req_full rises once the input queue is full; nothing is dropped.
module aes128_ctr_stream_cipher_core #(
   parameter int IN_QUEUE_DEPTH  = aesctr_pkg::IN_DEPTH,
   parameter int OUT_QUEUE_DEPTH = aesctr_pkg::OUT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  aesctr_pkg::req_type                 req_data,
   output logic                                req_full,
   output logic                                rsp_empty,
   output aesctr_pkg::rsp_type                 rsp_data,
   input  logic                                rsp_pop,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [aesctr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [aesctr_pkg::CSR_DATA_W-1:0]   csr_data
);
   import aesctr_pkg::*;

   logic [63:0] key_high_ff, key_high_in, key_low_ff, key_low_in;
   logic [63:0] ctr_high_ff, ctr_high_in, ctr_low_ff, ctr_low_in;
   logic        csr_write;
   req_type     in_item;
   logic        in_empty, in_pop;
   logic [127:0] ks_block;
   logic        ks_empty;
   ks_ctl_type  ks_ctl;
   logic        out_full, out_push;
   rsp_type     out_item;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      ctr_high_in = ctr_high_ff;
      ctr_low_in  = ctr_low_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_HIGH: key_high_in = csr_data;
            CSR_KEY_LOW:  key_low_in  = csr_data;
            CSR_CTR_HIGH: ctr_high_in = csr_data;
            CSR_CTR_LOW:  ctr_low_in  = csr_data;
            default:      key_high_in = key_high_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         ctr_high_ff <= '0;
         ctr_low_ff  <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
         ctr_high_ff <= ctr_high_in;
         ctr_low_ff  <= ctr_low_in;
      end
   end

   aesctr_fifo #(
      .WIDTH ($bits(req_type)),
      .DEPTH (IN_QUEUE_DEPTH)
   ) u_in_queue (
      .clock     (clock),
      .reset     (reset),
      .clear     (1'b0),
      .push      (req_push),
      .push_data (req_data),
      .full      (req_full),
      .pop       (in_pop),
      .pop_data  (in_item),
      .empty     (in_empty),
      .count     ()
   );

   // the keygen takes the counter after this cycle's write so a restart
   // reloads the freshly written value
   aesctr_keygen u_keygen (
      .clock    (clock),
      .reset    (reset),
      .key      ({key_high_ff, key_low_ff}),
      .init_ctr ({ctr_high_in, ctr_low_in}),
      .ctl      (ks_ctl),
      .ks_block (ks_block),
      .ks_empty (ks_empty)
   );

   aesctr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg_restart (csr_write),
      .in_item     (in_item),
      .in_empty    (in_empty),
      .in_pop      (in_pop),
      .ks_block    (ks_block),
      .ks_empty    (ks_empty),
      .ks_ctl      (ks_ctl),
      .out_full    (out_full),
      .out_push    (out_push),
      .out_item    (out_item)
   );

   aesctr_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .clear     (1'b0),
      .push      (out_push),
      .push_data (out_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty),
      .count     ()
   );

`ifndef SYNTH
   a_fire_has_keystream: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (!ks_empty && !in_empty))
      else $error("byte processed without keystream or input");

   a_restart_flushes: assert property (@(posedge clock) disable iff (reset)
      ks_ctl.restart |=> ks_empty)
      else $error("keystream queue not flushed after restart");

   a_pop_only_on_fire: assert property (@(posedge clock) disable iff (reset)
      ks_ctl.pop |-> out_push)
      else $error("keystream block released without a byte");
`endif

endmodule
